### design/fos_pkg.sv
`timescale 1ns / 1ps

package fos_pkg;

  // flash page size in bytes, and the kilobyte step that one page erase consumes
  localparam int PageBytes = 2048;
  localparam int PageKbRaw = PageBytes >> 10;
  localparam int PageKb    = (PageKbRaw == 0) ? 1 : PageKbRaw;

  localparam logic [31:0] PageAddrStep = 32'(PageBytes);
  localparam logic [15:0] PageKbStep   = 16'(PageKb);

  typedef enum logic [1:0] {
    KIND_PROGRAM = 2'd0,
    KIND_PAGE    = 2'd1,
    KIND_MASS    = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_IDLE    = 2'd0,
    OP_PROGRAM = 2'd1,
    OP_PAGE    = 2'd2,
    OP_MASS    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_PROGRAM    = 2'd1,
    CMD_ERASE_PAGE = 2'd2,
    CMD_MASS_ERASE = 2'd3
  } cmd_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] start_address;
    logic [15:0] amount;
    logic [15:0] halfword;
    logic        prog_error;
    logic        protect_error;
  } fos_item_t;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] target_address;
    logic [15:0] write_data;
    logic        start_refused;
    logic        finished;
    logic        aborted;
    logic [1:0]  error_flags;
    logic        active;
  } fos_result_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] addr;
    logic [15:0] remaining;
    logic [1:0]  errors;
  } fos_state_t;

endpackage

### design/fos_step.sv
`timescale 1ns / 1ps

// one event applied to the sequencer state: next state and the result item
module fos_step (
  input  fos_pkg::fos_state_t  state_i,
  input  fos_pkg::fos_item_t   item_i,
  output fos_pkg::fos_state_t  state_o,
  output fos_pkg::fos_result_t result_o
);

  logic [14:0] halfwords;
  logic [1:0]  errs;

  assign halfwords = item_i.amount[15:1];
  assign errs      = {item_i.protect_error, item_i.prog_error};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.command = fos_pkg::CMD_NONE;

    if (item_i.kind != fos_pkg::KIND_DONE) begin
      if (state_i.op != fos_pkg::OP_IDLE) begin
        result_o.start_refused = 1'b1;
      end else begin
        case (item_i.kind)
          fos_pkg::KIND_PROGRAM: begin
            if (halfwords == '0) begin
              // nothing to write, done at once
              result_o.finished = 1'b1;
            end else begin
              state_o.op        = fos_pkg::OP_PROGRAM;
              state_o.addr      = item_i.start_address;
              state_o.remaining = {1'b0, halfwords} - 16'd1;
              result_o.command        = fos_pkg::CMD_PROGRAM;
              result_o.target_address = item_i.start_address;
              result_o.write_data     = item_i.halfword;
            end
          end
          fos_pkg::KIND_PAGE: begin
            state_o.op        = fos_pkg::OP_PAGE;
            state_o.addr      = item_i.start_address;
            state_o.remaining = item_i.amount;
            result_o.command        = fos_pkg::CMD_ERASE_PAGE;
            result_o.target_address = item_i.start_address;
          end
          fos_pkg::KIND_MASS: begin
            state_o.op        = fos_pkg::OP_MASS;
            state_o.addr      = '0;
            state_o.remaining = '0;
            result_o.command  = fos_pkg::CMD_MASS_ERASE;
          end
          default: ;
        endcase
      end
    end else begin
      // error bits latch on every done, idle or not
      state_o.errors = errs;
      if (state_i.op != fos_pkg::OP_IDLE) begin
        if (errs != 2'b00) begin
          state_o.op        = fos_pkg::OP_IDLE;
          state_o.remaining = '0;
          result_o.aborted  = 1'b1;
        end else begin
          case (state_i.op)
            fos_pkg::OP_PROGRAM: begin
              if (state_i.remaining != '0) begin
                state_o.addr      = state_i.addr + 32'd2;
                state_o.remaining = state_i.remaining - 16'd1;
                result_o.command        = fos_pkg::CMD_PROGRAM;
                result_o.target_address = state_i.addr + 32'd2;
                result_o.write_data     = item_i.halfword;
              end else begin
                state_o.op        = fos_pkg::OP_IDLE;
                result_o.finished = 1'b1;
              end
            end
            fos_pkg::OP_PAGE: begin
              if (state_i.remaining > fos_pkg::PageKbStep) begin
                state_o.addr      = state_i.addr + fos_pkg::PageAddrStep;
                state_o.remaining = state_i.remaining - fos_pkg::PageKbStep;
                result_o.command        = fos_pkg::CMD_ERASE_PAGE;
                result_o.target_address = state_i.addr + fos_pkg::PageAddrStep;
              end else begin
                state_o.op        = fos_pkg::OP_IDLE;
                state_o.remaining = '0;
                result_o.finished = 1'b1;
              end
            end
            default: begin
              // mass erase completes on its first done
              state_o.op        = fos_pkg::OP_IDLE;
              result_o.finished = 1'b1;
            end
          endcase
        end
      end
    end

    result_o.error_flags = state_o.errors;
    result_o.active      = (state_o.op != fos_pkg::OP_IDLE);
  end

endmodule

### design/flash_operation_sequencer_top.sv
`timescale 1ns / 1ps

// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+---------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser kind, tdata event fields
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tuser command, tdata result fields
//
// every event gives exactly one result transaction, taken into the input register
// and then the result register; one event per cycle is sustained while the output
// is not stalled, set by the single input register -> step logic -> result register
// path with the state updated in the same cycle as the result is captured
// rst_ni clears the state (idle, address and counters zero, no latched errors)
// and both valid flags
// a stalled result register holds the event in the input register; s_axis_tready
// drops only when both registers are full and m_axis_tready is low
module flash_operation_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] start_address, [47:32] amount, [63:48] halfword,
  // [64] prog_error, [65] protect_error, [71:66] zero
  input  logic [71:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] target_address, [47:32] write_data, [48] start_refused,
  // [49] finished, [50] aborted, [52:51] error_flags, [53] active, [55:54] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] command
  output logic [1:0]  m_axis_tuser
);

  // input register
  logic                in_valid_q, in_valid_d;
  fos_pkg::fos_item_t  in_item_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  fos_pkg::fos_result_t out_res_q;

  // sequencer state
  fos_pkg::fos_state_t  state_q, state_d;
  fos_pkg::fos_result_t step_res;

  logic s_accept;
  logic advance;
  logic fire;

  // result stage may take a new value when empty or being drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  fos_step u_step (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.kind          <= fos_pkg::kind_e'(s_axis_tuser);
      in_item_q.start_address <= s_axis_tdata[31:0];
      in_item_q.amount        <= s_axis_tdata[47:32];
      in_item_q.halfword      <= s_axis_tdata[63:48];
      in_item_q.prog_error    <= s_axis_tdata[64];
      in_item_q.protect_error <= s_axis_tdata[65];
    end
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.command;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.active,
                          out_res_q.error_flags,
                          out_res_q.aborted,
                          out_res_q.finished,
                          out_res_q.start_refused,
                          out_res_q.write_data,
                          out_res_q.target_address};

  // an idle sequencer never keeps a count
  a_idle_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.op == fos_pkg::OP_IDLE |-> state_q.remaining == '0)
    else $error("idle with nonzero remaining count");

  // success and abort exclude each other
  a_fin_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.finished && out_res_q.aborted))
    else $error("result both finished and aborted");

  // an issued command always leaves an operation running
  a_cmd_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.command != fos_pkg::CMD_NONE |-> out_res_q.active)
    else $error("command issued while inactive");

  // a refused start issues nothing
  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.start_refused |->
      out_res_q.command == fos_pkg::CMD_NONE && out_res_q.active)
    else $error("refused start changed the operation");

  // state moves only with a processed event
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("state changed without an event");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

// flash sequencer bench: a directed table, then random well-formed operations
// with noise; every event gives one result, checked against a local model of
// the sequencer state
module tb_top;
  import fos_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 10;
  localparam int ItemsPerPhase = 440;

  typedef struct {
    fos_item_t   ev;
    bit          typed;
    fos_result_t res;
  } table_row_t;

  localparam fos_result_t NoTyped = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  fos_state_t  seq_model;
  fos_result_t predicted_results[$];
  table_row_t  directed_rows[$];
  int          mismatch_count = 0;
  int          events_sent = 0;
  int          stall_cycles = 0;
  int          sender_idle_pct = 23;
  int          receiver_idle_pct = 45;

  flash_operation_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one event through the sequencer model, updating its state
  function automatic fos_result_t step_sequencer(fos_item_t ev);
    fos_result_t r;
    logic [15:0] halfwords;
    r = '0;
    if (ev.kind != KIND_DONE) begin
      if (seq_model.op != OP_IDLE) begin
        r.start_refused = 1'b1;
      end else if (ev.kind == KIND_PROGRAM) begin
        halfwords = ev.amount >> 1;
        if (halfwords == 16'd0) begin
          r.finished = 1'b1;
        end else begin
          seq_model.op        = OP_PROGRAM;
          seq_model.addr      = ev.start_address;
          seq_model.remaining = halfwords - 16'd1;
          r.command           = CMD_PROGRAM;
          r.target_address    = ev.start_address;
          r.write_data        = ev.halfword;
        end
      end else if (ev.kind == KIND_PAGE) begin
        seq_model.op        = OP_PAGE;
        seq_model.addr      = ev.start_address;
        seq_model.remaining = ev.amount;
        r.command           = CMD_ERASE_PAGE;
        r.target_address    = ev.start_address;
      end else begin
        seq_model.op        = OP_MASS;
        seq_model.addr      = '0;
        seq_model.remaining = '0;
        r.command           = CMD_MASS_ERASE;
      end
    end else begin
      // errors latch on every done, idle or not
      seq_model.errors = {ev.protect_error, ev.prog_error};
      if (seq_model.op != OP_IDLE) begin
        if (seq_model.errors != 2'b00) begin
          seq_model.op        = OP_IDLE;
          seq_model.remaining = '0;
          r.aborted           = 1'b1;
        end else if (seq_model.op == OP_PROGRAM) begin
          if (seq_model.remaining != 16'd0) begin
            seq_model.addr      = seq_model.addr + 32'd2;
            seq_model.remaining = seq_model.remaining - 16'd1;
            r.command           = CMD_PROGRAM;
            r.target_address    = seq_model.addr;
            r.write_data        = ev.halfword;
          end else begin
            seq_model.op = OP_IDLE;
            r.finished   = 1'b1;
          end
        end else if (seq_model.op == OP_PAGE) begin
          if (seq_model.remaining > PageKbStep) begin
            seq_model.addr      = seq_model.addr + PageAddrStep;
            seq_model.remaining = seq_model.remaining - PageKbStep;
            r.command           = CMD_ERASE_PAGE;
            r.target_address    = seq_model.addr;
          end else begin
            seq_model.op        = OP_IDLE;
            seq_model.remaining = '0;
            r.finished          = 1'b1;
          end
        end else begin
          seq_model.op = OP_IDLE;
          r.finished   = 1'b1;
        end
      end
    end
    r.error_flags = seq_model.errors;
    r.active      = (seq_model.op != OP_IDLE);
    return r;
  endfunction

  function automatic fos_item_t make_event(kind_e k, logic [31:0] addr, logic [15:0] amount,
                                           logic [15:0] hw, logic [1:0] errs);
    fos_item_t ev;
    ev.kind          = k;
    ev.start_address = addr;
    ev.amount        = amount;
    ev.halfword      = hw;
    ev.prog_error    = errs[0];
    ev.protect_error = errs[1];
    return ev;
  endfunction

  function automatic table_row_t make_row(fos_item_t ev, bit typed, fos_result_t res);
    table_row_t row;
    row.ev    = ev;
    row.typed = typed;
    row.res   = res;
    return row;
  endfunction

  function automatic fos_item_t random_event(kind_e k);
    return make_event(k, $urandom, 16'($urandom), 16'($urandom), 2'($urandom));
  endfunction

  // address mix: anywhere, near the top for wrap-round, near zero
  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 32'hFFFF_FFFF - 32'($urandom_range(0, 8192));
    if (r < 25) return 32'($urandom_range(0, 4096));
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got_v, exp_v);
    mismatch_count++;
  endtask

  // drive one event, wait for its transaction and record the expected result
  task automatic send_event(fos_item_t ev, bit typed, fos_result_t typed_res);
    fos_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.kind;
    s_axis_tdata  <= {6'b0, ev.protect_error, ev.prog_error, ev.halfword, ev.amount,
                      ev.start_address};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = step_sequencer(ev);
    predicted_results.push_back(typed ? typed_res : predicted);
    events_sent++;
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
  endtask

  // a start (or a lone done), then done events until the operation ends; refused
  // starts and array errors are mixed in, long operations are cut short by an error
  task automatic run_random_operation();
    fos_item_t ev;
    int        pick;
    int        dones;
    int        cap;
    pick = $urandom_range(99);
    ev   = random_event(KIND_DONE);
    ev.start_address = pick_address();
    if (pick < 40) begin
      ev.kind = KIND_PROGRAM;
      pick    = $urandom_range(99);
      if (pick < 10)      ev.amount = 16'($urandom_range(0, 1));
      else if (pick < 85) ev.amount = 16'($urandom_range(2, 20));
    end else if (pick < 70) begin
      ev.kind = KIND_PAGE;
      if ($urandom_range(99) < 75) ev.amount = 16'($urandom_range(0, 12));
    end else if (pick < 85) begin
      ev.kind = KIND_MASS;
    end
    send_event(ev, 1'b0, NoTyped);
    dones = 0;
    cap   = $urandom_range(4, 16);
    while (seq_model.op != OP_IDLE) begin
      if ($urandom_range(99) < 6) begin
        ev = random_event(kind_e'($urandom_range(0, 2)));
      end else begin
        ev = random_event(KIND_DONE);
        dones++;
        if (dones >= cap) begin
          {ev.protect_error, ev.prog_error} = 2'($urandom_range(1, 3));
        end else if ($urandom_range(99) < 5) begin
          {ev.protect_error, ev.prog_error} = 2'($urandom_range(1, 3));
        end else begin
          {ev.protect_error, ev.prog_error} = 2'b00;
        end
      end
      send_event(ev, 1'b0, NoTyped);
    end
  endtask

  // receiver: random back-pressure, field-by-field check of each result
  always @(posedge clk_i) begin
    fos_result_t got;
    fos_result_t exp_res;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.command        = cmd_e'(m_axis_tuser);
        got.target_address = m_axis_tdata[31:0];
        got.write_data     = m_axis_tdata[47:32];
        got.start_refused  = m_axis_tdata[48];
        got.finished       = m_axis_tdata[49];
        got.aborted        = m_axis_tdata[50];
        got.error_flags    = m_axis_tdata[52:51];
        got.active         = m_axis_tdata[53];
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result, address", got.target_address, '0);
        end else begin
          exp_res = predicted_results.pop_front();
          if (got.command != exp_res.command)
            report_mismatch("command", 32'(got.command), 32'(exp_res.command));
          if (got.target_address != exp_res.target_address)
            report_mismatch("target_address", got.target_address, exp_res.target_address);
          if (got.write_data != exp_res.write_data)
            report_mismatch("write_data", 32'(got.write_data), 32'(exp_res.write_data));
          if (got.start_refused != exp_res.start_refused)
            report_mismatch("start_refused", 32'(got.start_refused), 32'(exp_res.start_refused));
          if (got.finished != exp_res.finished)
            report_mismatch("finished", 32'(got.finished), 32'(exp_res.finished));
          if (got.aborted != exp_res.aborted)
            report_mismatch("aborted", 32'(got.aborted), 32'(exp_res.aborted));
          if (got.error_flags != exp_res.error_flags)
            report_mismatch("error_flags", 32'(got.error_flags), 32'(exp_res.error_flags));
          if (got.active != exp_res.active)
            report_mismatch("active", 32'(got.active), 32'(exp_res.active));
        end
      end
      // watchdog on cycles with no transaction on either side
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", stall_cycles);
        $display("TEST FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    seq_model = '0;
    // directed table; typed expectations only where obvious
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00), 1'b1,
      fos_result_t'{CMD_NONE, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0, 2'b00, 1'b0}));
    // done while idle only latches the error bits
    directed_rows.push_back(make_row(
      make_event(KIND_DONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 2'b11), 1'b1,
      fos_result_t'{CMD_NONE, 32'h0, 16'h0, 1'b0, 1'b0, 1'b0, 2'b11, 1'b0}));
    // zero-halfword programs finish at once, odd byte dropped
    directed_rows.push_back(make_row(
      make_event(KIND_PROGRAM, 32'h0800_0000, 16'h0, 16'h1234, 2'b00), 1'b1,
      fos_result_t'{CMD_NONE, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0, 2'b11, 1'b0}));
    directed_rows.push_back(make_row(
      make_event(KIND_PROGRAM, 32'hFFFF_FFFF, 16'h1, 16'hFFFF, 2'b11), 1'b1,
      fos_result_t'{CMD_NONE, 32'h0, 16'h0, 1'b0, 1'b1, 1'b0, 2'b11, 1'b0}));
    directed_rows.push_back(make_row(
      make_event(KIND_PROGRAM, 32'hFFFF_FFFE, 16'h6, 16'hFFFF, 2'b00), 1'b1,
      fos_result_t'{CMD_PROGRAM, 32'hFFFF_FFFE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 2'b11, 1'b1}));
    // start while active is refused; program address wraps
    directed_rows.push_back(make_row(make_event(KIND_PAGE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'hA5A5, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_PROGRAM, 32'h0, 16'h4, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    // zero-kilobyte page erase still erases one page
    directed_rows.push_back(make_row(make_event(KIND_PAGE, 32'h0800_0000, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_MASS, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    // largest erase from the top of the space, wraps then aborts on a program error
    directed_rows.push_back(make_row(
      make_event(KIND_PAGE, 32'hFFFF_F800, 16'hFFFF, 16'h0, 2'b00), 1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b01),
      1'b0, NoTyped));
    // mass erase ignores address and amount
    directed_rows.push_back(make_row(
      make_event(KIND_MASS, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 2'b11), 1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_PROGRAM, 32'h0, 16'h2, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b10),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_MASS, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    // longest program, aborted by both errors
    directed_rows.push_back(make_row(
      make_event(KIND_PROGRAM, 32'h0000_1234, 16'hFFFF, 16'h5A5A, 2'b00), 1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b11),
      1'b0, NoTyped));
    // odd kilobyte count: two pages
    directed_rows.push_back(make_row(make_event(KIND_PAGE, 32'h100, 16'h3, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));
    directed_rows.push_back(make_row(make_event(KIND_DONE, 32'h0, 16'h0, 16'h0, 2'b00),
      1'b0, NoTyped));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 1: sender idles 23 %, receiver 45 %
    foreach (directed_rows[i]) send_event(directed_rows[i].ev, directed_rows[i].typed,
                                          directed_rows[i].res);
    // hold off until the sequencer has answered everything
    wait_for_drain();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        sender_idle_pct   = 45;
        receiver_idle_pct = 23;
      end else if (phase == 2) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      for (int op_count = 0; events_sent < ItemsPerPhase * (phase + 1); op_count++) begin
        run_random_operation();
        if (op_count % 50 == 49) wait_for_drain();
      end
      wait_for_drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
